@@ src/assert_macros.svh @@
// Assertion macros shared by the deframer modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every deframer module.
package wsd_pkg;

    // Width kept for the payload length and the payload position
    localparam int LENGTH_BITS = 64;
    localparam int LIMIT_BITS  = 16;

    // Header codes
    localparam logic [3:0] OP_CLOSE   = 4'd8;
    localparam logic [3:0] OP_PING    = 4'd9;
    localparam logic [3:0] OP_PONG    = 4'd10;
    localparam logic [3:0] OPCODE_MSK = 4'hf;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [2:0] EXT16_CNT  = 3'd1;
    localparam logic [2:0] EXT64_CNT  = 3'd7;
    localparam logic [2:0] KEY_CNT    = 3'd3;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

    typedef logic [LENGTH_BITS-1:0] t_len;

    typedef enum logic [1:0] {
        KIND_APP   = 2'd0,
        KIND_PING  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_PONG  = 2'd3
    } t_kind;

    // One result beat
    typedef struct packed {
        logic [7:0]            payload_byte;
        logic                  byte_valid;
        logic [3:0]            frame_opcode;
        t_kind                 frame_kind;
        logic                  frame_end;
        logic [LIMIT_BITS-1:0] delivered_length;
    } t_result;

endpackage

@@ src/wsd_parser.sv @@
// Frame header parser and payload unmasker: one byte per step.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_parser
    import wsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic [LIMIT_BITS-1:0] i_max_len,
    output logic                  o_res_valid,
    output t_result               o_res
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    t_len        r_len, n_len;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_key, n_key;
    t_len        r_pos, n_pos;

    t_kind       kind;
    logic [LIMIT_BITS-1:0] cap;
    logic [LIMIT_BITS-1:0] end_len;
    t_len        pos_inc;
    logic [7:0]  key_byte;
    logic [7:0]  unmasked;
    logic        last_byte;
    logic        under_limit;
    logic        hdr_mask;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_bvalid;
    logic        res_end;
    logic        do_header_done;
    logic        do_begin;

    // Frame kind from the opcode
    always_comb begin
        priority if (r_opcode == OP_CLOSE) kind = KIND_CLOSE;
        else if (r_opcode == OP_PING)      kind = KIND_PING;
        else if (r_opcode == OP_PONG)      kind = KIND_PONG;
        else                               kind = KIND_APP;
    end

    // Length reported with the end beat: min(length, cap)
    always_comb begin
        unique case (kind)
            KIND_APP:  cap = i_max_len;
            KIND_PING: cap = '1;
            default:   cap = '0;
        endcase
        if (((n_len >> LIMIT_BITS) == '0) && (n_len[LIMIT_BITS-1:0] < cap))
            end_len = n_len[LIMIT_BITS-1:0];
        else
            end_len = cap;
    end

    // Payload byte helpers
    assign pos_inc     = r_pos + t_len'(1);
    assign last_byte   = (pos_inc == r_len);
    assign under_limit = ((r_pos >> LIMIT_BITS) == '0) &&
                         (r_pos[LIMIT_BITS-1:0] < i_max_len);
    always_comb begin
        unique case (r_pos[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end
    assign unmasked = i_byte ^ key_byte;

    // Next state and result for the byte in the input register
    always_comb begin
        n_phase        = r_phase;
        n_opcode       = r_opcode;
        n_mask         = r_mask;
        n_len          = r_len;
        n_cnt          = r_cnt;
        n_key          = r_key;
        n_pos          = r_pos;
        res_valid      = 1'b0;
        res_byte       = '0;
        res_bvalid     = 1'b0;
        res_end        = 1'b0;
        hdr_mask       = r_mask;
        do_header_done = 1'b0;
        do_begin       = 1'b0;

        unique case (r_phase)
            PH_HDR1: begin
                n_mask   = i_byte[7];
                hdr_mask = i_byte[7];
                if ((i_byte[6:0] == LEN_EXT16) || (i_byte[6:0] == LEN_EXT64)) begin
                    n_len   = '0;
                    n_cnt   = (i_byte[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
                    n_phase = PH_EXT;
                end else begin
                    n_len          = t_len'(i_byte[6:0]);
                    do_header_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_len = {r_len[LENGTH_BITS-9:0], i_byte};
                if (r_cnt == '0) begin
                    do_header_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_cnt == '0) begin
                    do_begin = 1'b1;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_DATA: begin
                n_pos = pos_inc;
                if (last_byte) n_phase = PH_HDR0;
                unique case (kind)
                    KIND_APP: begin
                        if (last_byte || under_limit) begin
                            res_valid  = 1'b1;
                            res_bvalid = under_limit;
                            res_byte   = under_limit ? unmasked : 8'd0;
                            res_end    = last_byte;
                        end
                    end
                    KIND_PING: begin
                        res_valid  = 1'b1;
                        res_bvalid = 1'b1;
                        res_byte   = unmasked;
                        res_end    = last_byte;
                    end
                    KIND_CLOSE: begin
                        res_valid = last_byte;
                        res_end   = last_byte;
                    end
                    default: ;
                endcase
            end
            default: begin
                n_opcode = i_byte[3:0] & OPCODE_MSK;
                n_phase  = PH_HDR1;
            end
        endcase

        // Header complete: key next, or straight to the payload
        if (do_header_done) begin
            n_key = '0;
            if (hdr_mask) begin
                n_cnt   = KEY_CNT;
                n_phase = PH_KEY;
            end else begin
                do_begin = 1'b1;
            end
        end

        // Payload start; an empty frame ends here
        if (do_begin) begin
            n_pos = '0;
            if (n_len != '0) begin
                n_phase = PH_DATA;
            end else begin
                n_phase = PH_HDR0;
                if (kind != KIND_PONG) begin
                    res_valid = 1'b1;
                    res_end   = 1'b1;
                end
            end
        end
    end

    assign o_res_valid            = i_step && res_valid;
    assign o_res.payload_byte     = res_byte;
    assign o_res.byte_valid       = res_bvalid;
    assign o_res.frame_opcode     = r_opcode;
    assign o_res.frame_kind       = kind;
    assign o_res.frame_end        = res_end;
    assign o_res.delivered_length = res_end ? end_len : '0;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

    // A beat without a byte only ever closes a frame
    `ASSERT_CLK(a_empty_beat_ends, (o_res_valid && !o_res.byte_valid) |-> o_res.frame_end,
        "result without byte is not a frame end")
    // Pong frames never reach the output
    `ASSERT_CLK(a_no_pong, o_res_valid |-> (o_res.frame_kind != KIND_PONG),
        "pong result emitted")
    // After a frame end the parser waits for a new header
    `ASSERT_CLK(a_end_to_hdr, (o_res_valid && o_res.frame_end) |=> (r_phase == PH_HDR0),
        "parser not back at header after frame end")

endmodule

@@ src/wsd_out_skid.sv @@
// Result register with one skid entry, so the ready towards the parser is registered.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_out_skid
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_can_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop        = r_out_valid && i_ready;
    assign o_can_take = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (r_out_valid && !pop && i_push) begin
            r_skid <= i_data;
        end
    end

    // The skid entry is only used behind a full output register
    `ASSERT_ALWAYS(a_skid_behind_out, (i_rst_n && r_skid_valid) |-> r_out_valid,
        "skid entry valid with empty output register")
    // A beat pushed into a stalled full register lands in the skid entry
    `ASSERT_CLK(a_push_to_skid, (i_push && r_out_valid && !i_ready) |=> r_skid_valid,
        "stalled push lost")
    // No push while the skid entry is occupied
    `ASSERT_CLK(a_no_overrun, r_skid_valid |-> !i_push, "push into full buffer")

endmodule

@@ src/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer top level: input byte register, limit register,
// parser and result buffer. Depends on wsd_pkg, wsd_parser and wsd_out_skid.
//
// Use: received stream bytes enter on the s_axis beat channel, one byte in
// s_axis_tdata per beat. Results leave on m_axis: tdata carries the unmasked
// byte, the opcode and the delivered length; tuser carries byte_valid and the
// frame kind; tlast marks the last beat of a frame. Header bytes, mask key
// bytes, pong payload, close payload and application bytes past the limit
// give no beat unless they end a frame other than a pong. i_cfg_wen with
// i_cfg_wdata sets the application byte limit (65535 after reset); write it
// only while the block is idle. Throughput: one byte per cycle unless the
// skid entry is in use; each beat is registered in the result buffer.
// Reset (synchronous, active low) returns the parser to waiting for a first
// header byte and empties the input and result registers.
// When the receiver stalls, the result register, one skid entry and the input
// byte register fill up; s_axis_tready then drops and all data is kept.
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] payload_byte, [11:8] frame_opcode, [27:12] delivered_length, [31:28] zero
    output logic [31:0]           m_axis_tdata,
    // [0] byte_valid, [2:1] frame_kind
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast,  // frame_end
    input  logic                  i_cfg_wen,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata    // max_message_len
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [LIMIT_BITS-1:0] r_max_len;
    logic                  can_take;
    logic                  step;
    logic                  res_valid;
    t_result               res;
    t_result               out_res;

    assign step          = r_in_valid && can_take;
    assign s_axis_tready = !r_in_valid || step;

    // Input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in_byte <= s_axis_tdata;
    end

    // Byte limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LIMIT_RESET;
        end else if (i_cfg_wen) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_skid u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_data     (res),
        .o_can_take (can_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (out_res)
    );

    // Pack the result beat
    assign m_axis_tdata = {4'd0, out_res.delivered_length, out_res.frame_opcode,
                           out_res.payload_byte};
    assign m_axis_tuser = {out_res.frame_kind, out_res.byte_valid};
    assign m_axis_tlast = out_res.frame_end;

endmodule

@@ tb/ws_deframe_checker.sv @@
// Scoreboard for the WebSocket frame deframer: follows the received byte stream,
// predicts every result beat and compares it field by field on m_axis.
// Depends on wsd_pkg for the result layout, frame kinds and header constants.
module ws_deframe_checker
    import wsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    input  logic                  i_rx_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [31:0]           i_res_data,
    input  logic [2:0]            i_res_user,
    input  logic                  i_res_last,
    input  logic                  i_cfg_wen,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata,
    output int                    o_results_due,
    output int                    o_fail_count
);

    typedef enum logic [2:0] {
        WAIT_OPCODE,
        WAIT_LENGTH,
        EXT_LENGTH,
        KEY_BYTES,
        PAYLOAD
    } t_parse_phase;

    // Mirror of the parser state
    t_parse_phase          phase;
    logic [3:0]            cur_opcode;
    logic                  masked;
    t_len                  frame_len;
    t_len                  frame_pos;
    logic [2:0]            bytes_left;
    logic [31:0]           mask_key;
    logic [LIMIT_BITS-1:0] msg_limit;

    t_result results_due[$];
    int      fails = 0;

    function automatic t_kind opcode_kind(input logic [3:0] op);
        if (op == OP_CLOSE) return KIND_CLOSE;
        if (op == OP_PING) return KIND_PING;
        if (op == OP_PONG) return KIND_PONG;
        return KIND_APP;
    endfunction

    // Length reported with the frame's last beat
    function automatic logic [LIMIT_BITS-1:0] closing_length(input t_kind k);
        if (k == KIND_APP) return (frame_len < t_len'(msg_limit)) ? frame_len[15:0] : msg_limit;
        if (k == KIND_PING) return (frame_len < t_len'(16'hffff)) ? frame_len[15:0] : 16'hffff;
        return '0;
    endfunction

    function automatic t_result result_beat(input logic [7:0] b, input logic valid,
                                            input t_kind k, input logic last);
        t_result r;
        r.payload_byte     = valid ? b : 8'h00;
        r.byte_valid       = valid;
        r.frame_opcode     = cur_opcode;
        r.frame_kind       = k;
        r.frame_end        = last;
        r.delivered_length = last ? closing_length(k) : '0;
        return r;
    endfunction

    // Header complete: either payload follows or the frame is already over
    function automatic bit open_payload(output t_result r);
        t_kind k;
        k = opcode_kind(cur_opcode);
        frame_pos = '0;
        if (frame_len != '0) begin
            phase = PAYLOAD;
            return 1'b0;
        end
        phase = WAIT_OPCODE;
        if (k == KIND_PONG) return 1'b0;
        r = result_beat(8'h00, 1'b0, k, 1'b1);
        return 1'b1;
    endfunction

    function automatic bit finish_header(output t_result r);
        mask_key = '0;
        if (masked) begin
            bytes_left = KEY_CNT;
            phase      = KEY_BYTES;
            return 1'b0;
        end
        return open_payload(r);
    endfunction

    // One received byte; returns 1 when it causes a result beat
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        t_kind      k;
        t_len       pos;
        t_len       nxt;
        logic [7:0] clear;
        logic       last;
        logic       valid;
        int         idx;
        r = '0;
        case (phase)
            WAIT_LENGTH: begin
                masked = b[7];
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    frame_len  = '0;
                    bytes_left = (b[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
                    phase      = EXT_LENGTH;
                    return 1'b0;
                end
                frame_len = t_len'(b[6:0]);
                return finish_header(r);
            end
            EXT_LENGTH: begin
                frame_len = {frame_len[LENGTH_BITS-9:0], b};
                if (bytes_left == 3'd0) return finish_header(r);
                bytes_left = bytes_left - 3'd1;
                return 1'b0;
            end
            KEY_BYTES: begin
                mask_key = {mask_key[23:0], b};
                if (bytes_left == 3'd0) return open_payload(r);
                bytes_left = bytes_left - 3'd1;
                return 1'b0;
            end
            PAYLOAD: begin
                pos   = frame_pos;
                idx   = 3 - int'(pos[1:0]);
                clear = b ^ mask_key[8*idx +: 8];
                nxt   = pos + t_len'(1);
                last  = (nxt == frame_len);
                k     = opcode_kind(cur_opcode);
                frame_pos = nxt;
                if (last) phase = WAIT_OPCODE;
                case (k)
                    KIND_APP: begin
                        valid = (pos < t_len'(msg_limit));
                        if (!last && !valid) return 1'b0;
                        r = result_beat(clear, valid, KIND_APP, last);
                        return 1'b1;
                    end
                    KIND_PING: begin
                        r = result_beat(clear, 1'b1, KIND_PING, last);
                        return 1'b1;
                    end
                    KIND_CLOSE: begin
                        if (!last) return 1'b0;
                        r = result_beat(8'h00, 1'b0, KIND_CLOSE, 1'b1);
                        return 1'b1;
                    end
                    default: return 1'b0;
                endcase
            end
            default: begin
                cur_opcode = b[3:0] & OPCODE_MSK;
                phase      = WAIT_LENGTH;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic note_failure(input string what, input int want, input int seen);
        fails++;
        if (fails <= 10) begin
            $display("deframer mismatch on %s: expected 0x%0h, got 0x%0h", what, want, seen);
        end
    endtask

    // Predict on every accepted input beat, compare on every accepted result beat
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result seen;
        bit      fired;
        if (!i_rst_n) begin
            phase      = WAIT_OPCODE;
            cur_opcode = '0;
            masked     = 1'b0;
            frame_len  = '0;
            frame_pos  = '0;
            bytes_left = '0;
            mask_key   = '0;
            msg_limit  = LIMIT_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_wen) msg_limit = i_cfg_wdata;
            if (i_rx_valid && i_rx_ready) begin
                fired = deframe_byte(i_rx_byte, want);
                if (fired) results_due.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                seen.payload_byte     = i_res_data[7:0];
                seen.frame_opcode     = i_res_data[11:8];
                seen.delivered_length = i_res_data[27:12];
                seen.byte_valid       = i_res_user[0];
                seen.frame_kind       = t_kind'(i_res_user[2:1]);
                seen.frame_end        = i_res_last;
                if (results_due.size() == 0) begin
                    note_failure("beat with nothing due, tdata", 0, int'(i_res_data));
                end else begin
                    want = results_due.pop_front();
                    if (want.payload_byte !== seen.payload_byte)
                        note_failure("payload_byte", int'(want.payload_byte),
                                     int'(seen.payload_byte));
                    if (want.byte_valid !== seen.byte_valid)
                        note_failure("byte_valid", int'(want.byte_valid),
                                     int'(seen.byte_valid));
                    if (want.frame_opcode !== seen.frame_opcode)
                        note_failure("frame_opcode", int'(want.frame_opcode),
                                     int'(seen.frame_opcode));
                    if (want.frame_kind !== seen.frame_kind)
                        note_failure("frame_kind", int'(want.frame_kind), int'(seen.frame_kind));
                    if (want.frame_end !== seen.frame_end)
                        note_failure("frame_end", int'(want.frame_end), int'(seen.frame_end));
                    if (want.delivered_length !== seen.delivered_length)
                        note_failure("delivered_length", int'(want.delivered_length),
                                     int'(seen.delivered_length));
                end
            end
        end
        o_results_due <= results_due.size();
        o_fail_count  <= fails;
    end

endmodule

@@ tb/tb_websocket_frame_deframer_top.sv @@
// Testbench top for websocket_frame_deframer_top: builds WebSocket frame byte
// streams, drives them with random gaps and stalls, and gives the verdict.
// Depends on wsd_pkg, the deframer RTL and ws_deframe_checker.
module tb_websocket_frame_deframer_top;
    import wsd_pkg::*;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_wen     = 1'b0;
    logic [LIMIT_BITS-1:0] i_cfg_wdata   = '0;

    int         results_due;
    int         fail_count;
    logic       gaps_on   = 1'b0;  // random idling on both sides
    int         sink_hold = 0;
    logic [7:0] rx_stream[$];

    websocket_frame_deframer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    ws_deframe_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (s_axis_tvalid),
        .i_rx_ready    (s_axis_tready),
        .i_rx_byte     (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .i_res_last    (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_results_due (results_due),
        .o_fail_count  (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result sink: ready runs alternate with stalls, mostly short, a few long
    always @(posedge i_clk) begin : result_sink
        int roll;
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_axis_tready && gaps_on) begin
            m_axis_tready <= 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 75) sink_hold <= $urandom_range(0, 2);
            else if (roll < 95) sink_hold <= $urandom_range(3, 8);
            else sink_hold <= $urandom_range(15, 40);
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold     <= gaps_on ? $urandom_range(0, 12) : 0;
        end
    end

    // Queue one frame: header, optional extended length, optional key, body
    task automatic push_frame(input logic [7:0] head0, input logic masked, input int len_form,
                              input t_len len, input int body_bytes);
        logic [6:0] len_code;
        len_code = (len_form == 1) ? LEN_EXT16 : (len_form == 2) ? LEN_EXT64 : len[6:0];
        rx_stream.push_back(head0);
        rx_stream.push_back({masked, len_code});
        if (len_form == 1) begin
            for (int i = 1; i >= 0; i--) rx_stream.push_back(len[8*i +: 8]);
        end else if (len_form == 2) begin
            for (int i = 7; i >= 0; i--) rx_stream.push_back(len[8*i +: 8]);
        end
        if (masked) repeat (4) rx_stream.push_back(8'($urandom_range(0, 255)));
        repeat (body_bytes) rx_stream.push_back(8'($urandom_range(0, 255)));
    endtask

    // Send every queued byte, one beat per handshake, with random gaps
    task automatic flush_stream();
        int gap;
        int roll;
        while (rx_stream.size() != 0) begin
            gap = 0;
            if (gaps_on) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) gap = 0;
                else if (roll < 90) gap = $urandom_range(1, 3);
                else if (roll < 98) gap = $urandom_range(4, 10);
                else gap = $urandom_range(15, 40);
            end
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= rx_stream.pop_front();
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Limit change only once the block has drained
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        do @(posedge i_clk); while (results_due != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [LIMIT_BITS-1:0] lim;
        logic [7:0]            head0;
        logic [3:0]            opc;
        t_len                  len;
        int                    form;
        int                    roll;
        int                    v;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_limit(LIMIT_RESET);
        gaps_on <= 1'b1;

        // Directed: empty application, ping and pong frames, close body, fragment ping, 16-bit length
        push_frame({4'h8, 4'h1}, 1'b0, 0, t_len'(0), 0);
        push_frame({4'h8, OP_PING}, 1'b1, 0, t_len'(0), 0);
        push_frame({4'h8, OP_PONG}, 1'b0, 0, t_len'(0), 0);
        push_frame({4'h8, OP_CLOSE}, 1'b0, 0, t_len'(2), 2);
        push_frame({4'h0, OP_PING}, 1'b1, 0, t_len'(2), 2);
        push_frame({4'hf, 4'hf}, 1'b0, 1, t_len'(1), 1);
        flush_stream();

        // Random frames under a range of limits
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: lim = '0;
                1: lim = LIMIT_RESET;
                2: lim = 16'd1;
                3: lim = 16'($urandom_range(2, 8));
                4: lim = 16'($urandom_range(0, 65535));
                5: lim = 16'($urandom_range(9, 24));
                6: lim = 16'h7fff;
                default: lim = 16'd3;
            endcase
            write_limit(lim);
            gaps_on <= ($urandom_range(0, 3) != 0);
            while (rx_stream.size() < 25) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    opc = 4'($urandom_range(0, 2));
                end else if (roll < 55) begin
                    // reserved codes, handled as application data
                    v   = $urandom_range(0, 9);
                    opc = (v < 5) ? 4'(3 + v) : 4'(6 + v);
                end else if (roll < 70) begin
                    opc = OP_PING;
                end else if (roll < 82) begin
                    opc = OP_PONG;
                end else begin
                    opc = OP_CLOSE;
                end
                head0 = {4'($urandom_range(0, 15)), opc};
                if ($urandom_range(0, 9) == 0) head0 = 8'($urandom_range(0, 255));
                roll = $urandom_range(0, 99);
                form = 0;
                if (roll < 10) begin
                    len = '0;
                end else if (roll < 70) begin
                    len = t_len'($urandom_range(1, 20));
                end else if (roll < 80) begin
                    len = t_len'((roll < 72) ? 125 : $urandom_range(21, 60));
                end else if (roll < 90) begin
                    form = 1;
                    len  = t_len'($urandom_range(0, 40));
                end else if (roll < 97) begin
                    form = 2;
                    len  = t_len'($urandom_range(0, 40));
                end else begin
                    form = 1;
                    len  = t_len'($urandom_range(126, 200));
                end
                push_frame(head0, 1'($urandom_range(0, 1)), form, len, int'(len));
            end
            flush_stream();

            // One longer application frame with a 16-bit length, no idling
            if (p == 3) begin
                write_limit(16'($urandom_range(32768, 65535)));
                gaps_on <= 1'b0;
                len = t_len'($urandom_range(130, 150));
                push_frame({4'h8, 4'h2}, 1'($urandom_range(0, 1)), 1, len, int'(len));
                flush_stream();
            end
        end

        // Length with the top bit set: the frame never ends, bytes past the limit drop
        write_limit(16'($urandom_range(4, 12)));
        gaps_on <= 1'b1;
        len = {$urandom, $urandom};
        len[LENGTH_BITS-1] = 1'b1;
        push_frame({4'h8, 4'h2}, 1'b1, 2, len, 40);
        flush_stream();

        do @(posedge i_clk); while (results_due != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
